FILE: rtl/core/rdd_pkg.sv
// Shared types and constants of the relocation delta decoder.
package rdd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 31;
   localparam int unsigned STAT_W  = 2;

   localparam logic [WORD_W-1:0]  START_POS = 32'hFFFF_FFFC;
   localparam logic [WORD_W-1:0]  POS_BIAS  = 32'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;
   localparam logic [BYTE_W-1:0]  LONG_LEAD = 8'hF0;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OFFSET  = 2'd0,
      ST_END     = 2'd1,
      ST_OVERLAP = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   // Byte position within one encoded delta
   typedef enum logic [6:0] {
      PH_LEAD   = 7'b000_0001,
      PH_EXT_LO = 7'b000_0010,
      PH_EXT_HI = 7'b000_0100,
      PH_W0     = 7'b000_1000,
      PH_W1     = 7'b001_0000,
      PH_W2     = 7'b010_0000,
      PH_W3     = 7'b100_0000
   } phase_type;

   // What the assembled byte asks of the position tracker
   typedef struct packed {
      logic              apply;
      logic              finish;
      logic [WORD_W-1:0] delta;
   } cmd_type;

endpackage

FILE: rtl/core/rdd_byte_asm.sv
// Assembles lead, extension and long-form bytes into complete deltas.
module rdd_byte_asm
   import rdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              halt,
   input  logic [BYTE_W-1:0] stream_byte,
   output cmd_type           cmd
);

   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] accum_ff, accum_in;
   logic [WORD_W-1:0] ext_word;

   assign ext_word = accum_ff | {16'd0, stream_byte, 8'd0};

   always_comb begin
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      cmd.apply  = 1'b0;
      cmd.finish = 1'b0;
      cmd.delta  = ext_word;
      unique case (phase_ff)
         PH_LEAD: begin
            cmd.delta = {24'd0, stream_byte};
            if (stream_byte == '0) begin
               cmd.finish = 1'b1;
               accum_in   = '0;
            end else if (stream_byte < LONG_LEAD) begin
               cmd.apply = 1'b1;
               accum_in  = '0;
            end else begin
               accum_in = {12'd0, stream_byte[3:0], 16'd0};
               phase_in = PH_EXT_LO;
            end
         end
         PH_EXT_LO: begin
            accum_in = accum_ff | {24'd0, stream_byte};
            phase_in = PH_EXT_HI;
         end
         PH_EXT_HI: begin
            // zero extension escapes to a full 32-bit delta
            if (ext_word == '0) begin
               accum_in = '0;
               phase_in = PH_W0;
            end else begin
               cmd.apply = 1'b1;
               accum_in  = '0;
               phase_in  = PH_LEAD;
            end
         end
         PH_W0: begin
            accum_in = accum_ff | {24'd0, stream_byte};
            phase_in = PH_W1;
         end
         PH_W1: begin
            accum_in = accum_ff | {16'd0, stream_byte, 8'd0};
            phase_in = PH_W2;
         end
         PH_W2: begin
            accum_in = accum_ff | {8'd0, stream_byte, 16'd0};
            phase_in = PH_W3;
         end
         PH_W3: begin
            cmd.delta = accum_ff | {stream_byte, 24'd0};
            cmd.apply = 1'b1;
            accum_in  = '0;
            phase_in  = PH_LEAD;
         end
         default: begin
            phase_in = PH_LEAD;
            accum_in = '0;
         end
      endcase
      if (!step || halt) begin
         phase_in   = phase_ff;
         accum_in   = accum_ff;
         cmd.apply  = 1'b0;
         cmd.finish = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

endmodule

FILE: rtl/core/rdd_reloc_apply.sv
// Tracks the running position and count, checks each delta, registers the result.
module rdd_reloc_apply
   import rdd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cmd_type            cmd,
   input  logic               csr_wr_en,
   input  logic [WORD_W-1:0]  csr_wr_data,
   output logic               halt,
   output logic               rsp_valid,
   output status_type         rsp_status,
   output logic [WORD_W-1:0]  rsp_offset,
   output logic [COUNT_W-1:0] rsp_count
);

   logic [WORD_W-1:0]  image_size_ff;
   logic [WORD_W-1:0]  position_ff, position_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               halt_ff, halt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [WORD_W-1:0]  offset_ff, offset_in;
   logic [COUNT_W-1:0] rcount_ff, rcount_in;
   logic [WORD_W-1:0]  next_pos;
   logic               overlap;
   logic               outside;

   assign next_pos = position_ff + cmd.delta;
   // deltas 0..3 and anything negative as signed overlap the previous fixup
   assign overlap  = cmd.delta[WORD_W-1] || (cmd.delta[WORD_W-2:2] == '0);
   assign outside  = (next_pos + POS_BIAS) > image_size_ff;

   always_comb begin
      position_in  = position_ff;
      count_in     = count_ff;
      halt_in      = halt_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      offset_in    = offset_ff;
      rcount_in    = rcount_ff;
      if (advance) begin
         rsp_valid_in = cmd.apply || cmd.finish;
         offset_in    = '0;
         rcount_in    = count_ff;
         status_in    = ST_END;
         if (cmd.finish) begin
            position_in = START_POS;
            count_in    = '0;
         end else if (overlap) begin
            status_in = ST_OVERLAP;
            halt_in   = halt_ff || cmd.apply;
         end else if (outside) begin
            status_in = ST_RANGE;
            halt_in   = halt_ff || cmd.apply;
         end else if (cmd.apply) begin
            status_in   = ST_OFFSET;
            position_in = next_pos;
            offset_in   = next_pos;
            count_in    = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
            rcount_in   = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '1;
         position_ff   <= START_POS;
         count_ff      <= '0;
         halt_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            image_size_ff <= csr_wr_data;
         end
         position_ff  <= position_in;
         count_ff     <= count_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      offset_ff <= offset_in;
      rcount_ff <= rcount_in;
   end

   assign halt       = halt_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_offset = offset_ff;
   assign rsp_count  = rcount_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("error halt cleared without reset");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_OVERLAP || status_ff == ST_RANGE) |-> halt_ff)
      else $error("error reported without halting");

   a_offset_is_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_OFFSET |-> offset_ff == position_ff)
      else $error("reported offset differs from running position");

   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      advance && cmd.finish |=> position_ff == START_POS && count_ff == '0)
      else $error("end of list did not rearm position and count");

endmodule

FILE: rtl/core/reloc_delta_decoder.sv
// Relocation delta decoder: compressed byte stream in, absolute offsets out.
//
// req_* carries one stream byte per transfer. rsp_* carries zero or one
// result per byte: an absolute offset, an end-of-list marker with the
// count, or an overlap/range error. After an error the block drops every
// further byte without a result until reset.
// csr_wr_en / csr_wr_data write the image size; write only while idle.
// A byte passes through one input register and then one result register.
// Throughput: one byte per cycle while the receiver does not stall; the
// delta add and image-size compare are combinational.
// The input register keeps taking a byte while a finished result waits on
// a stalled receiver; with both registers full req_tready drops until the
// receiver takes the result.
// Reset (synchronous, active high) empties both registers, sets the image
// size to all ones, the position to -4, the count to zero and clears the
// error halt.
module reloc_delta_decoder
   import rdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] stream_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,   // [1:0] status, [33:2] reloc_offset,
                                          // [64:34] reloc_count, [71:65] zero
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               advance;
   logic               step;
   logic               halt;
   cmd_type            cmd;
   status_type         status;
   logic [WORD_W-1:0]  offset;
   logic [COUNT_W-1:0] count;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   rdd_byte_asm u_asm (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .halt        (halt),
      .stream_byte (in_byte_ff),
      .cmd         (cmd)
   );

   rdd_reloc_apply u_apply (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .halt        (halt),
      .rsp_valid   (rsp_tvalid),
      .rsp_status  (status),
      .rsp_offset  (offset),
      .rsp_count   (count)
   );

   assign rsp_tdata = {7'd0, count, offset, status};

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the relocation delta decoder: stream bytes in, results checked.
module tb;
   import rdd_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_STALL  = 300;

   typedef struct {
      status_type       status;
      bit [WORD_W-1:0]  offset;
      bit [COUNT_W-1:0] count;
   } reloc_result_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [71:0]       rsp_tdata;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;

   bit [7:0]         pending_bytes[$];
   reloc_result_type expected_relocs[$];

   // decoder state as predicted
   phase_type        dec_phase;
   bit [WORD_W-1:0]  dec_accum;
   bit [WORD_W-1:0]  dec_pos;
   bit [COUNT_W-1:0] dec_count;
   bit               dec_halt;
   bit [WORD_W-1:0]  dec_size;

   // stream generator bookkeeping
   bit [WORD_W-1:0]  gen_pos;
   bit [WORD_W-1:0]  gen_size;

   int tx_idle_pct;
   int rx_idle_pct;
   int stall_asks;
   int stall_seen;
   int rx_hold;
   int quiet_cycles;
   int errors;

   reloc_delta_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic void commit_delta(input bit [WORD_W-1:0] d);
      bit [WORD_W-1:0] np;
      bit [WORD_W-1:0] top;
      dec_phase = PH_LEAD;
      dec_accum = '0;
      if (d == 0 || d[31] || d < 4) begin
         dec_halt = 1'b1;
         expected_relocs.push_back('{status: ST_OVERLAP, offset: '0, count: dec_count});
         return;
      end
      np  = dec_pos + d;
      top = np + POS_BIAS;
      if (top > dec_size) begin
         dec_halt = 1'b1;
         expected_relocs.push_back('{status: ST_RANGE, offset: '0, count: dec_count});
         return;
      end
      dec_pos = np;
      if (dec_count != COUNT_MAX)
         dec_count++;
      expected_relocs.push_back('{status: ST_OFFSET, offset: dec_pos, count: dec_count});
   endfunction

   function automatic void decode_reloc_byte(input bit [7:0] b);
      if (dec_halt)
         return;
      case (dec_phase)
         PH_EXT_LO: begin
            dec_accum |= {24'd0, b};
            dec_phase = PH_EXT_HI;
         end
         PH_EXT_HI: begin
            dec_accum |= {16'd0, b, 8'd0};
            // zero extension announces a full 32-bit delta
            if (dec_accum == 0)
               dec_phase = PH_W0;
            else
               commit_delta(dec_accum);
         end
         PH_W0: begin
            dec_accum |= {24'd0, b};
            dec_phase = PH_W1;
         end
         PH_W1: begin
            dec_accum |= {16'd0, b, 8'd0};
            dec_phase = PH_W2;
         end
         PH_W2: begin
            dec_accum |= {8'd0, b, 16'd0};
            dec_phase = PH_W3;
         end
         PH_W3: begin
            dec_accum |= {b, 24'd0};
            commit_delta(dec_accum);
         end
         default: begin
            dec_phase = PH_LEAD;
            if (b == 0) begin
               expected_relocs.push_back('{status: ST_END, offset: '0, count: dec_count});
               dec_pos   = START_POS;
               dec_count = '0;
               dec_accum = '0;
            end else if (b < LONG_LEAD) begin
               commit_delta({24'd0, b});
            end else begin
               dec_accum = {12'd0, b[3:0], 16'd0};
               dec_phase = PH_EXT_LO;
            end
         end
      endcase
   endfunction

   // driver: offer queued bytes, predict on each transfer
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         dec_phase  = PH_LEAD;
         dec_accum  = '0;
         dec_pos    = START_POS;
         dec_count  = '0;
         dec_halt   = 1'b0;
         dec_size   = '1;
      end else begin
         if (req_tvalid && req_tready)
            decode_reloc_byte(req_tdata);
         if (!req_tvalid || req_tready) begin
            offer = pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct;
            if (offer) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         rx_hold    <= 0;
         stall_seen <= 0;
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else if (stall_seen != stall_asks) begin
         rx_hold    <= LONG_STALL;
         stall_seen <= stall_asks;
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      reloc_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_relocs.size() == 0) begin
               $error("unexpected result transfer: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_relocs.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  errors++;
               end
               if (rsp_tdata[33:2] !== want.offset) begin
                  $error("reloc_offset: expected %h, got %h", want.offset, rsp_tdata[33:2]);
                  errors++;
               end
               if (rsp_tdata[64:34] !== want.count) begin
                  $error("reloc_count: expected %0d, got %0d", want.count, rsp_tdata[64:34]);
                  errors++;
               end
               if (rsp_tdata[71:65] !== 7'd0) begin
                  $error("pad: expected 0, got %h", rsp_tdata[71:65]);
                  errors++;
               end
            end
         end
         rsp_tready <= (rx_hold == 0) && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_image_size(input bit [WORD_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      dec_size = v;
      gen_size = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // hold until every byte is taken and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_relocs.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_seq(input bit [7:0] seq[$]);
      foreach (seq[i])
         pending_bytes.push_back(seq[i]);
   endtask

   // well-formed deltas that stay inside the image; end the list when one would not
   task automatic gen_stream(input int n);
      int              pushed;
      int              kind;
      bit [WORD_W-1:0] d;
      bit [WORD_W-1:0] np;
      bit [WORD_W-1:0] top;
      bit [7:0]        enc[$];
      pushed = 0;
      while (pushed < n) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            enc = '{8'h00};
            gen_pos = START_POS;
         end else begin
            if (kind < 55) begin
               d = $urandom_range(4, 239);
               enc = '{d[7:0]};
            end else if (kind < 85) begin
               d = $urandom_range(4, 20'hF_FFFF);
               enc = '{{4'hF, d[19:16]}, d[7:0], d[15:8]};
            end else begin
               if ($urandom_range(1))
                  d = $urandom_range(4, 16'hFFFF);
               else
                  d = $urandom_range(4, 32'h7FFF_FFFF);
               enc = '{LONG_LEAD, 8'h00, 8'h00, d[7:0], d[15:8], d[23:16], d[31:24]};
            end
            np  = gen_pos + d;
            top = np + POS_BIAS;
            if (top > gen_size) begin
               enc = '{8'h00};
               gen_pos = START_POS;
            end else begin
               gen_pos = np;
            end
         end
         push_seq(enc);
         pushed += enc.size();
      end
      pending_bytes.push_back(8'h00);
      gen_pos = START_POS;
   endtask

   initial begin
      bit [7:0]        noise[$];
      bit [WORD_W-1:0] big;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      tx_idle_pct = 6;
      rx_idle_pct = 68;
      stall_asks  = 0;
      errors      = 0;
      gen_pos     = START_POS;
      gen_size    = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, short extremes, extension, long deltas up to wrap
      write_image_size(32'hFFFF_FFFF);
      push_seq('{8'h00, 8'h04, 8'hEF, 8'hF0, 8'h00, 8'h01, 8'hFF, 8'h34, 8'h12,
                 8'hF0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                 8'hF0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00});
      wait_idle();

      // slow receiver, with one long hold-off while bytes keep coming
      stall_asks++;
      gen_stream(330);
      wait_idle();

      // slow sender, mid-sized image, pause in between
      tx_idle_pct = 68;
      rx_idle_pct = 6;
      write_image_size($urandom_range(1000, 32'h00FF_FFFF));
      gen_stream(170);
      wait_idle();
      gen_stream(170);
      wait_idle();

      // tiny images allow nothing but end markers
      write_image_size(32'd1);
      push_seq('{8'h00, 8'h00, 8'h00});
      wait_idle();
      write_image_size(32'd0);
      push_seq('{8'h00, 8'h00});
      wait_idle();

      // full rate, random image size, with one long receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_image_size($urandom);
      stall_asks++;
      gen_stream(330);
      wait_idle();

      // one error halts the block for the rest of the run
      if ($urandom_range(1)) begin
         write_image_size($urandom_range(1) ? 32'd0 : 32'($urandom_range(0, 8'hEE)));
         pending_bytes.push_back(8'hEF);
      end else begin
         big = $urandom;
         case ($urandom_range(3))
            0: pending_bytes.push_back(8'($urandom_range(1, 3)));
            1: push_seq('{LONG_LEAD, 8'h00, 8'h00, big[7:0], big[15:8], big[23:16],
                          big[31:24] | 8'h80});
            2: push_seq('{LONG_LEAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
            default: push_seq('{LONG_LEAD, 8'($urandom_range(1, 3)), 8'h00});
         endcase
      end
      repeat (40) noise.push_back(8'($urandom));
      push_seq(noise);
      wait_idle();

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rdd_pkg.sv
rtl/core/rdd_byte_asm.sv
rtl/core/rdd_reloc_apply.sv
rtl/core/reloc_delta_decoder.sv
tb/sv/tb.sv
